@@ rtl/sldw_pkg.sv @@
// Shared types and constants for the status LED and watchdog driver.
package sldw_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_BLINK_PERIOD   = 2'd0;
  localparam logic [1:0] CFG_ACTIVITY_WINDOW = 2'd1;
  localparam logic [1:0] CFG_KICK_PERIOD    = 2'd2;

  // Register reset values
  localparam logic [15:0] BLINK_PERIOD_RST    = 16'd500;
  localparam logic [15:0] ACTIVITY_WINDOW_RST = 16'd1200;
  localparam logic [7:0]  KICK_PERIOD_RST     = 8'd5;

  // Bit positions in the out_byte image
  localparam int unsigned BIT_RUN  = 5;
  localparam int unsigned BIT_CON  = 3;
  localparam int unsigned BIT_KICK = 0;

  // Classified polling pass, front to back
  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] now_s;
    logic        link_up;
    logic        con_active;  // link up and activity recent
  } pass_t;

  // One result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_write;
  } result_t;

endpackage

@@ rtl/status_led_watchdog_driver.sv @@
// Top level of the status LED and watchdog driver.
// Each beat pushed in is one polling pass and yields exactly one result beat.
// The block takes one pass per clock cycle while full is low; an accepted
// pass waits in the classified-pass queue until the back end steps it into
// the result queue, which it does only while the result queue has room.
// The back end updates the run LED, connection LED and watchdog state once for
// every pass that it steps, using three 32-bit elapsed-time
// compares. full rises only after pops have stalled long enough for the result
// queue and then the classified-pass queue to fill. out_byte carries bit 5 run
// LED, bit 3 connection LED and bit 0 watchdog; out_write flags a byte that
// differs from the one last sent. Configuration must be written while no pass
// is in flight; register indexes 0, 1, 2 are blink period (ms), activity
// window (s) and kick period (s); other indexes are ignored.
module status_led_watchdog_driver
  import sldw_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // pass input
  input  logic        push,
  output logic        full,
  input  logic [31:0] now_ms,
  input  logic [31:0] now_s,
  input  logic        link_up,
  input  logic [31:0] last_activity_s,
  // result output
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_write
);

  logic [15:0] blink_period_ms;
  logic [15:0] activity_window_s;
  logic [7:0]  kick_period_s;

  pass_t   front_pass;
  pass_t   back_pass;
  logic    pass_empty;
  logic    result_full;
  logic    step;
  result_t back_result;
  result_t head_result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period_ms   <= BLINK_PERIOD_RST;
      activity_window_s <= ACTIVITY_WINDOW_RST;
      kick_period_s     <= KICK_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLINK_PERIOD:    blink_period_ms   <= cfg_data;
        CFG_ACTIVITY_WINDOW: activity_window_s <= cfg_data;
        CFG_KICK_PERIOD:     kick_period_s     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Front: classify the incoming pass
  sldw_front u_front (
    .activity_window_s (activity_window_s),
    .now_ms            (now_ms),
    .now_s             (now_s),
    .link_up           (link_up),
    .last_activity_s   (last_activity_s),
    .pass              (front_pass)
  );

  // Queue of classified passes
  sldw_fifo #(
    .WIDTH ($bits(pass_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_pass_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_pass),
    .rd_en   (step),
    .rd_data (back_pass),
    .full    (full),
    .empty   (pass_empty)
  );

  // Back: LED and watchdog state
  sldw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .blink_period_ms (blink_period_ms),
    .kick_period_s   (kick_period_s),
    .pass_valid      (!pass_empty),
    .pass            (back_pass),
    .result_full     (result_full),
    .step            (step),
    .result          (back_result)
  );

  // Result queue
  sldw_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (step),
    .wr_data (back_result),
    .rd_en   (pop),
    .rd_data (head_result),
    .full    (result_full),
    .empty   (empty)
  );

  assign out_byte  = head_result.out_byte;
  assign out_write = head_result.out_write;

endmodule

@@ rtl/sldw_fifo.sv @@
// Small register-based queue used between the front, the back and the result port.
module sldw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ rtl/sldw_front.sv @@
// Front end: classifies each polling pass before it is queued for the back end.
module sldw_front
  import sldw_pkg::*;
(
  input  logic [15:0] activity_window_s,
  input  logic [31:0] now_ms,
  input  logic [31:0] now_s,
  input  logic        link_up,
  input  logic [31:0] last_activity_s,
  output pass_t       pass
);

  logic [31:0] idle_s;
  logic        recent;

  // Activity is recent when it exists and is strictly inside the window
  assign idle_s = now_s - last_activity_s;
  assign recent = (last_activity_s != '0) && (idle_s < {16'd0, activity_window_s});

  always_comb begin
    pass.now_ms     = now_ms;
    pass.now_s      = now_s;
    pass.link_up    = link_up;
    pass.con_active = link_up && recent;
  end

endmodule

@@ rtl/sldw_back.sv @@
// Back end: LED and watchdog state, image build and change detection.
module sldw_back
  import sldw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] blink_period_ms,
  input  logic [7:0]  kick_period_s,
  input  logic        pass_valid,
  input  pass_t       pass,
  input  logic        result_full,
  output logic        step,
  output result_t     result
);

  logic        run_on;
  logic [31:0] run_mark_ms;
  logic        con_on;
  logic [31:0] con_mark_ms;
  logic        kick_on;
  logic [31:0] kick_mark_s;
  logic [2:0]  sent;

  logic        run_fire;
  logic        con_fire;
  logic        kick_fire;
  logic        run_on_next;
  logic        con_on_next;
  logic        kick_on_next;
  logic [2:0]  image_next;
  logic [7:0]  byte_next;

  assign step = pass_valid && !result_full;

  // Toggle conditions: elapsed time modulo 2^32 strictly above the period
  assign run_fire  = !pass.link_up &&
                     ((pass.now_ms - run_mark_ms) > {16'd0, blink_period_ms});
  assign con_fire  = pass.con_active &&
                     ((pass.now_ms - con_mark_ms) > {16'd0, blink_period_ms});
  assign kick_fire = (pass.now_s - kick_mark_s) > {24'd0, kick_period_s};

  // Next LED and watchdog levels
  always_comb begin
    if (pass.link_up) begin
      run_on_next = 1'b1;
    end else begin
      run_on_next = run_fire ? !run_on : run_on;
    end
    if (pass.con_active) begin
      con_on_next = con_fire ? !con_on : con_on;
    end else begin
      con_on_next = 1'b0;
    end
    kick_on_next = kick_fire ? !kick_on : kick_on;
    image_next   = {run_on_next, con_on_next, kick_on_next};

    byte_next           = '0;
    byte_next[BIT_RUN]  = run_on_next;
    byte_next[BIT_CON]  = con_on_next;
    byte_next[BIT_KICK] = kick_on_next;

    result.out_byte  = byte_next;
    result.out_write = (image_next != sent);
  end

  // State update, one pass per step
  always_ff @(posedge clk) begin
    if (rst) begin
      run_on      <= 1'b0;
      run_mark_ms <= '0;
      con_on      <= 1'b0;
      con_mark_ms <= '0;
      kick_on     <= 1'b0;
      kick_mark_s <= '0;
      sent        <= '0;
    end else if (step) begin
      run_on  <= run_on_next;
      con_on  <= con_on_next;
      kick_on <= kick_on_next;
      sent    <= image_next;
      if (run_fire) begin
        run_mark_ms <= pass.now_ms;
      end
      if (con_fire) begin
        con_mark_ms <= pass.now_ms;
      end
      if (kick_fire) begin
        kick_mark_s <= pass.now_s;
      end
    end
  end

`ifndef SYNTHESIS
  // A pass with the link up leaves the run LED on and its mark untouched
  a_run_forced: assert property (@(posedge clk) disable iff (rst)
    step && pass.link_up |=> run_on && $stable(run_mark_ms))
    else $error("run LED not forced on while link up");

  // Without recent activity the connection LED is off and its mark holds
  a_con_off: assert property (@(posedge clk) disable iff (rst)
    step && !pass.con_active |=> !con_on && $stable(con_mark_ms))
    else $error("connection LED not held off");

  // After a step the sent image matches the state bits
  a_sent_track: assert property (@(posedge clk) disable iff (rst)
    step |=> sent == {run_on, con_on, kick_on})
    else $error("sent image out of step with LED state");

  // The sent image and the kick mark move only on a step
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step && !$past(rst) |=> $stable(sent) && $stable(kick_mark_s))
    else $error("state changed without a step");
`endif

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the status LED and watchdog driver.
`timescale 1ns / 100ps

// Tracks the LED and watchdog image the block should produce for each pass
class status_image_tracker;
  logic [15:0] blink_ms;
  logic [15:0] window_s;
  logic [7:0]  kick_s;

  logic        run_on;
  logic [31:0] run_mark;
  logic        con_on;
  logic [31:0] con_mark;
  logic        kick_on;
  logic [31:0] kick_mark;
  logic [7:0]  image;
  logic [7:0]  sent;

  sldw_pkg::result_t image_q[$];
  int unsigned       errors;

  function new();
    blink_ms  = sldw_pkg::BLINK_PERIOD_RST;
    window_s  = sldw_pkg::ACTIVITY_WINDOW_RST;
    kick_s    = sldw_pkg::KICK_PERIOD_RST;
    run_on    = 1'b0;
    run_mark  = '0;
    con_on    = 1'b0;
    con_mark  = '0;
    kick_on   = 1'b0;
    kick_mark = '0;
    image     = '0;
    sent      = '0;
    errors    = 0;
  endfunction

  // Register write; the kick period keeps only its low byte
  function void set_reg(logic [1:0] idx, logic [15:0] data);
    case (idx)
      sldw_pkg::CFG_BLINK_PERIOD:    blink_ms = data;
      sldw_pkg::CFG_ACTIVITY_WINDOW: window_s = data;
      sldw_pkg::CFG_KICK_PERIOD:     kick_s   = data[7:0];
      default: ;
    endcase
  endfunction

  // One accepted polling pass: update the image and queue the beat it yields
  function void note_pass(logic [31:0] ms, logic [31:0] s, logic lk, logic [31:0] act);
    logic [31:0]       run_gap;
    logic [31:0]       con_gap;
    logic [31:0]       act_age;
    logic [31:0]       kick_gap;
    logic              recent;
    sldw_pkg::result_t beat;

    run_gap  = ms - run_mark;
    con_gap  = ms - con_mark;
    act_age  = s - act;
    kick_gap = s - kick_mark;

    // run LED: steady while linked, blinking otherwise
    if (lk) begin
      run_on = 1'b1;
      image[sldw_pkg::BIT_RUN] = 1'b1;
    end else if (run_gap > {16'b0, blink_ms}) begin
      run_mark = ms;
      run_on = ~run_on;
      image[sldw_pkg::BIT_RUN] = run_on;
    end

    // connection LED: blinks only with recent socket activity
    recent = lk && (act != 0) && (act_age < {16'b0, window_s});
    if (recent) begin
      if (con_gap > {16'b0, blink_ms}) begin
        con_mark = ms;
        con_on = ~con_on;
        image[sldw_pkg::BIT_CON] = con_on;
      end
    end else begin
      con_on = 1'b0;
      image[sldw_pkg::BIT_CON] = 1'b0;
    end

    // watchdog toggle
    if (kick_gap > {24'b0, kick_s}) begin
      kick_mark = s;
      kick_on = ~kick_on;
      image[sldw_pkg::BIT_KICK] = kick_on;
    end

    beat.out_byte  = image;
    beat.out_write = (image != sent);
    if (beat.out_write) sent = image;
    image_q.push_back(beat);
  endfunction

  // Compare one popped beat with the oldest queued image
  function void check_beat(logic [7:0] got_byte, logic got_write);
    sldw_pkg::result_t want;

    if (image_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected beat out_byte=%h out_write=%b", $realtime, got_byte,
                 got_write);
      return;
    end
    want = image_q.pop_front();
    if (got_byte !== want.out_byte || got_write !== want.out_write) begin
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch out_byte exp=%h got=%h, out_write exp=%b got=%b",
                 $realtime, want.out_byte, got_byte, want.out_write, got_write);
    end
  endfunction

  function int unsigned waiting();
    return image_q.size();
  endfunction
endclass

module testbench;
  import sldw_pkg::*;

  // index 3 is decoded by nobody; written once to show it is ignored
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        push;
  logic        full;
  logic [31:0] now_ms;
  logic [31:0] now_s;
  logic        link_up;
  logic [31:0] last_activity_s;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        out_write;

  status_image_tracker tracker = new();

  // stimulus-side view of the settings and the running clocks
  logic [15:0] cur_blink = BLINK_PERIOD_RST;
  logic [15:0] cur_window = ACTIVITY_WINDOW_RST;
  logic [7:0]  cur_kick = KICK_PERIOD_RST;
  logic [31:0] cur_ms;
  logic [31:0] cur_s;
  logic        cur_link;
  bit          tx_gaps;

  int unsigned rx_stall = 0;
  int unsigned rx_quiet = 0;

  status_led_watchdog_driver u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .now_ms(now_ms),
    .now_s(now_s),
    .link_up(link_up),
    .last_activity_s(last_activity_s),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .out_write(out_write)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls with quiet stretches of steady popping
  always @(negedge clk) begin
    if (rx_stall != 0) begin
      pop = 1'b0;
      rx_stall--;
    end else begin
      pop = 1'b1;
      if (rx_quiet != 0) rx_quiet--;
      else if ($urandom_range(0, 149) == 0) rx_quiet = $urandom_range(40, 120);
      else rx_stall = gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) tracker.check_beat(out_byte, out_write);
  end

  task automatic send_pass(input logic [31:0] ms, input logic [31:0] s, input logic lk,
                           input logic [31:0] act);
    int unsigned gap;
    @(negedge clk);
    push = 1'b1;
    now_ms = ms;
    now_s = s;
    link_up = lk;
    last_activity_s = act;
    do @(posedge clk); while (full !== 1'b0);
    tracker.note_pass(ms, s, lk, act);
    if (tx_gaps) begin
      gap = gap_len();
      if (gap != 0) begin
        @(negedge clk);
        push = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // drain: every pass yields a beat, then allow the pipeline depth
  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    tracker.set_reg(idx, data);
    case (idx)
      CFG_BLINK_PERIOD:    cur_blink = data;
      CFG_ACTIVITY_WINDOW: cur_window = data;
      CFG_KICK_PERIOD:     cur_kick = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_all(input logic [15:0] blink, input logic [15:0] window,
                         input logic [15:0] kick);
    write_reg(CFG_BLINK_PERIOD, blink);
    write_reg(CFG_ACTIVITY_WINDOW, window);
    write_reg(CFG_KICK_PERIOD, kick);
  endtask

  // activity stamp around the edges of the recent window
  function automatic logic [31:0] pick_activity(logic [31:0] s, logic [15:0] window);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 45) return s - $urandom_range(0, window);
    if (r < 55) return s - window + 32'd1;
    if (r < 65) return s - window;
    if (r < 75) return s + $urandom_range(1, 20);
    if (r < 85) return $urandom;
    return s - $urandom_range(0, 3);
  endfunction

  // mostly advancing time with steps near the periods, some jumps and noise
  task automatic random_pass();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 82) begin
      case ($urandom_range(0, 9))
        0, 1:    cur_ms += cur_blink + $urandom_range(0, 1);
        2:       cur_ms += $urandom_range(0, 3 * cur_blink + 2);
        default: cur_ms += $urandom_range(0, cur_blink / 2 + 2);
      endcase
      case ($urandom_range(0, 9))
        0, 1:    cur_s += cur_kick + $urandom_range(0, 1);
        default: cur_s += $urandom_range(0, cur_kick / 2 + 1);
      endcase
      if ($urandom_range(0, 99) < 8) cur_link = ~cur_link;
      send_pass(cur_ms, cur_s, cur_link, pick_activity(cur_s, cur_window));
    end else if (r < 92) begin
      cur_ms = $urandom;
      cur_s = $urandom;
      cur_link = 1'($urandom_range(0, 1));
      send_pass(cur_ms, cur_s, cur_link, pick_activity(cur_s, cur_window));
    end else begin
      send_pass($urandom, $urandom, 1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) tx_gaps = ($urandom_range(0, 3) != 0);
      random_pass();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_BLINK_PERIOD;
    cfg_data = '0;
    push = 1'b0;
    now_ms = '0;
    now_s = '0;
    link_up = 1'b0;
    last_activity_s = '0;
    tx_gaps = 1'b0;
    cur_link = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed passes at reset settings
    send_pass(32'd0, 32'd0, 1'b0, 32'd0);
    send_pass(32'd500, 32'd5, 1'b0, 32'd0);           // equal to period: no toggle
    send_pass(32'd501, 32'd6, 1'b0, 32'd0);           // just past: toggles
    send_pass(32'd1001, 32'd11, 1'b0, 32'd0);
    send_pass(32'd1002, 32'd12, 1'b0, 32'd0);
    send_pass(32'd1100, 32'd12, 1'b1, 32'd0);         // linked, never active
    send_pass(32'd1200, 32'd20, 1'b1, 32'd20 - 32'd1199);  // last recent second
    send_pass(32'd1300, 32'd20, 1'b1, 32'd20 - 32'd1200);  // window reached
    send_pass(32'd1400, 32'd20, 1'b1, 32'd21);        // activity in the future
    send_pass(32'd1800, 32'd20, 1'b1, 32'd20);
    send_pass(32'd1801, 32'd20, 1'b1, 32'd20);
    send_pass(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_pass(32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);     // time runs backwards
    send_pass(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0);
    send_pass(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA);
    send_pass(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'h5555_5555);
    send_pass(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h5555_5554);
    cur_ms = 32'hAAAA_AAAA;
    cur_s = 32'h5555_5555;
    run_random(140);
    drain();

    // smallest periods
    set_all(16'd1, 16'd1, 16'd1);
    run_random(90);
    drain();

    // largest periods, clocks about to wrap
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
    cur_ms = 32'hFFFC_0000;
    cur_s = 32'hFFFF_FF00;
    run_random(100);
    drain();

    // zero periods and window
    set_all(16'd0, 16'd0, 16'h0000);
    run_random(70);
    drain();

    // middling values, kick written with junk in the upper byte
    write_reg(CFG_UNUSED, 16'($urandom));
    set_all(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 3000)),
            {8'($urandom), 8'($urandom_range(1, 20))});
    cur_ms = 32'hFFFF_F000;
    run_random(140);
    drain();

    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.waiting() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/sldw_pkg.sv
rtl/sldw_fifo.sv
rtl/sldw_front.sv
rtl/sldw_back.sv
rtl/status_led_watchdog_driver.sv
verif/testbench.sv
